@@ rtl/superio_config_register_block_macros.svh @@
// ----------------------------------------------------------------------------
// superio config register block assertion macros
// shared concurrent assertion forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef SUPERIO_CONFIG_REGISTER_BLOCK_MACROS_SVH
`define SUPERIO_CONFIG_REGISTER_BLOCK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SIO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sio assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SIO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sio assertion failed");

`endif

@@ rtl/sio_cfg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sio_cfg_pkg
// shared constants, types and reset values of the super i/o config port
// ----------------------------------------------------------------------------
package sio_cfg_pkg;

    localparam int unsigned MAX_INDEX     = 21;
    localparam int unsigned REG9_INIT     = 9;
    localparam bit          DISK_START_ON = 1'b0;

    localparam int unsigned NREGS = MAX_INDEX + 1;
    localparam int unsigned IDX_W = $clog2(NREGS);

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // port offsets
    localparam logic [1:0] PORT_KEY      = 2'd0;
    localparam logic [1:0] PORT_INDEX    = 2'd1;
    localparam logic [1:0] PORT_DATA     = 2'd2;
    localparam logic [1:0] PORT_DATA_ALT = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CFG0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_CFG1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CFG3 = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_CFG4 = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_CFG6 = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_CFG7 = IDX_W'(7);
    localparam logic [IDX_W-1:0] REG_CFG9 = IDX_W'(9);
    localparam logic [IDX_W-1:0] REG_CFGA = IDX_W'(10);
    localparam logic [IDX_W-1:0] REG_CFGC = IDX_W'(12);
    localparam logic [IDX_W-1:0] REG_CFGD = IDX_W'(13);

    localparam logic [7:0] KEY_BASE   = 8'h88;
    localparam logic [7:0] REG6_MASK  = 8'hF3;
    localparam logic [7:0] REG7_RMASK = 8'h0F;
    localparam logic [7:0] READ_IDLE  = 8'hFF;
    localparam logic [7:0] REG0_DEF   = 8'hD0;
    localparam logic [7:0] REG0_SEC   = 8'h90;
    localparam logic [7:0] REG0_DISK  = 8'h7F;

    // ide presence codes
    localparam logic [1:0] IDE_NONE = 2'd0;

    // floppy and disk mode codes
    localparam logic [1:0] MODE_OFF       = 2'd0;
    localparam logic [1:0] MODE_PRIMARY   = 2'd1;
    localparam logic [1:0] MODE_SECONDARY = 2'd2;

    // standard resource bases and irq lines
    localparam logic [9:0] COM_3F8 = 10'h3F8;
    localparam logic [9:0] COM_2F8 = 10'h2F8;
    localparam logic [9:0] COM_3E8 = 10'h3E8;
    localparam logic [9:0] COM_2E8 = 10'h2E8;
    localparam logic [9:0] LPT_3BC = 10'h3BC;
    localparam logic [9:0] LPT_278 = 10'h278;
    localparam logic [9:0] LPT_378 = 10'h378;
    localparam logic [3:0] IRQ3    = 4'd3;
    localparam logic [3:0] IRQ4    = 4'd4;
    localparam logic [3:0] IRQ5    = 4'd5;
    localparam logic [3:0] IRQ7    = 4'd7;

    // post-update register values that feed the resource decode
    typedef struct packed {
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] r3;
        logic [7:0] r4;
        logic [7:0] r6;
        logic [1:0] ide;
    } dec_regs_t;

    // decoded resource assignment
    typedef struct packed {
        logic [9:0] uart_a_addr;
        logic [3:0] uart_a_irq;
        logic       uart_a_on;
        logic [9:0] uart_b_addr;
        logic [3:0] uart_b_irq;
        logic       uart_b_on;
        logic [9:0] printer_addr;
        logic [3:0] printer_irq;
        logic       printer_on;
        logic [1:0] floppy_mode;
        logic [1:0] disk_mode;
    } res_t;

    // strap default of register 0 for a given ide setting
    function automatic logic [7:0] reg0_strap(logic [1:0] ide);
        logic [7:0] v;
        v = REG0_DEF;
        if (ide != IDE_NONE)
        begin
            if (ide[1])
                v = REG0_SEC;
            if (DISK_START_ON)
                v = v & REG0_DISK;
        end
        return v;
    endfunction

    // reset value of each register with ide absent
    function automatic logic [7:0] reg_reset(logic [IDX_W-1:0] i);
        logic [7:0] v;
        v = 8'h00;
        case (i)
            REG_CFG0: v = reg0_strap(IDE_NONE);
            REG_CFG1: v = 8'h2C;
            REG_CFG3: v = 8'h30;
            REG_CFG7: v = 8'hF5;
            REG_CFG9: v = 8'(REG9_INIT);
            REG_CFGA: v = 8'h1F;
            REG_CFGC: v = 8'h2C;
            REG_CFGD: v = 8'hA3;
            default:  v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/superio_config_register_block.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superio_config_register_block
// configuration port of a super i/o chip: key unlock, index and data
// accesses, write lock, and decoded serial, parallel, floppy and ide
// resources on every beat
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     in_valid / in_stall        operation, port_offset, write_data
//  output    out_valid / out_stall      read_data, uart_*, printer_*, floppy/disk
//  config    cfg_write_en               cfg_write_data (ide presence)
//
//  one beat per cycle while out_stall is low; an accepted beat sits in the input
//  register, moves into the result register once that has room and leaves it
//  again when out_stall is low
//  the register file update and the decode sit between those two registers
//  reset loads all register defaults at once; there is no clearing pass
//  an output stall holds the result register and backs up into the input
//  register; in_stall rises only when both stages are full
// ----------------------------------------------------------------------------
`include "superio_config_register_block_macros.svh"

module superio_config_register_block (
    input  logic       clk,
    input  logic       rst_n,

    // access beats in
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [1:0] port_offset,
    input  logic [7:0] write_data,

    // result beats out
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [9:0] uart_a_addr,
    output logic [3:0] uart_a_irq,
    output logic       uart_a_on,
    output logic [9:0] uart_b_addr,
    output logic [3:0] uart_b_irq,
    output logic       uart_b_on,
    output logic [9:0] printer_addr,
    output logic [3:0] printer_irq,
    output logic       printer_on,
    output logic [1:0] floppy_mode,
    output logic [1:0] disk_mode,

    // ide presence strap register
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_write_data
);

    // input stage
    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [1:0] s1_port_reg;
    logic [7:0] s1_data_reg;

    // result stage
    logic              out_valid_reg;
    logic [7:0]        rd_reg;
    sio_cfg_pkg::res_t res_reg;

    logic                   out_room;
    logic                   s1_move;
    logic                   in_take;
    logic [7:0]             rd_next;
    sio_cfg_pkg::dec_regs_t dec_regs;
    sio_cfg_pkg::res_t      res_next;

    // result register frees up when empty or when its beat leaves
    assign out_room = !out_valid_reg || !out_stall;
    // the beat in the input register is processed as it moves on
    assign s1_move  = s1_valid_reg && out_room;
    assign in_stall = s1_valid_reg && !out_room;
    assign in_take  = in_valid && !in_stall;

    sio_cfg_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_move),
        .op       (s1_op_reg),
        .port     (s1_port_reg),
        .wdata    (s1_data_reg),
        .cfg_we   (cfg_write_en),
        .cfg_data (cfg_write_data),
        .rdata    (rd_next),
        .dec      (dec_regs)
    );

    sio_cfg_decode u_decode (
        .regs_in (dec_regs),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (out_room)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg   <= operation;
            s1_port_reg <= port_offset;
            s1_data_reg <= write_data;
        end
        if (s1_move)
        begin
            rd_reg  <= rd_next;
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_reg;
    assign uart_a_addr  = res_reg.uart_a_addr;
    assign uart_a_irq   = res_reg.uart_a_irq;
    assign uart_a_on    = res_reg.uart_a_on;
    assign uart_b_addr  = res_reg.uart_b_addr;
    assign uart_b_irq   = res_reg.uart_b_irq;
    assign uart_b_on    = res_reg.uart_b_on;
    assign printer_addr = res_reg.printer_addr;
    assign printer_irq  = res_reg.printer_irq;
    assign printer_on   = res_reg.printer_on;
    assign floppy_mode  = res_reg.floppy_mode;
    assign disk_mode    = res_reg.disk_mode;

    // a stall on the input side only happens with a beat waiting inside
    `SIO_ASSERT_NOW(a_stall_needs_beat, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg)
    // a beat moved out of the input register always lands in the result register
    `SIO_ASSERT_NEXT(a_move_lands, clk, rst_n, s1_move, out_valid_reg)
    // a stalled result is never dropped
    `SIO_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)

endmodule

@@ rtl/sio_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sio_cfg_regs
// register file, key unlock, index and write lock with read mux
// ----------------------------------------------------------------------------
`include "superio_config_register_block_macros.svh"

module sio_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  op,
    input  logic [1:0]            port,
    input  logic [7:0]            wdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_data,
    output logic [7:0]            rdata,
    output sio_cfg_pkg::dec_regs_t dec
);

    logic [7:0]                    regs_reg [sio_cfg_pkg::NREGS];
    logic [1:0]                    ide_reg;
    logic                          unlocked_reg;
    logic                          unlocked_next;
    logic [sio_cfg_pkg::IDX_W-1:0] index_reg;
    logic [sio_cfg_pkg::IDX_W-1:0] index_next;
    logic                          lock_reg;
    logic                          lock_next;
    logic                          wr_en;
    logic [7:0]                    wr_val;
    logic [7:0]                    key;
    logic [7:0]                    cur;

    assign key = sio_cfg_pkg::KEY_BASE | {7'b0, regs_reg[sio_cfg_pkg::REG_CFGC][5]};
    assign cur = regs_reg[index_reg];

    always_comb
    begin
        wr_en         = 1'b0;
        wr_val        = wdata;
        unlocked_next = unlocked_reg;
        index_next    = index_reg;
        lock_next     = lock_reg;
        if (index_reg == sio_cfg_pkg::REG_CFG6)
            wr_val = wdata & sio_cfg_pkg::REG6_MASK;
        if (step && op == sio_cfg_pkg::OP_WRITE)
        begin
            case (port)
                sio_cfg_pkg::PORT_KEY:
                    unlocked_next = (wdata == key);
                sio_cfg_pkg::PORT_INDEX:
                begin
                    if (wdata <= 8'(sio_cfg_pkg::MAX_INDEX))
                        index_next = sio_cfg_pkg::IDX_W'(wdata);
                end
                default:
                begin
                    wr_en = unlocked_reg && !lock_reg;
                    // lock follows bit 6 only when a write to register 9 flips it
                    if (wr_en && index_reg == sio_cfg_pkg::REG_CFG9
                        && (cur[6] != wr_val[6]))
                        lock_next = wr_val[6];
                end
            endcase
        end
    end

    // read data from the state before this beat
    always_comb
    begin
        rdata = sio_cfg_pkg::READ_IDLE;
        if (op == sio_cfg_pkg::OP_READ && unlocked_reg)
        begin
            if (port == sio_cfg_pkg::PORT_INDEX)
                rdata = 8'(index_reg);
            else if (port == sio_cfg_pkg::PORT_DATA)
            begin
                if (index_reg == sio_cfg_pkg::REG_CFG7)
                    rdata = cur & sio_cfg_pkg::REG7_RMASK;
                else if (!lock_reg)
                    rdata = cur;
            end
        end
    end

    // values after this beat for the resource decode
    always_comb
    begin
        dec.r0  = (wr_en && index_reg == sio_cfg_pkg::REG_CFG0) ? wr_val
                : regs_reg[sio_cfg_pkg::REG_CFG0];
        dec.r1  = (wr_en && index_reg == sio_cfg_pkg::REG_CFG1) ? wr_val
                : regs_reg[sio_cfg_pkg::REG_CFG1];
        dec.r3  = (wr_en && index_reg == sio_cfg_pkg::REG_CFG3) ? wr_val
                : regs_reg[sio_cfg_pkg::REG_CFG3];
        dec.r4  = (wr_en && index_reg == sio_cfg_pkg::REG_CFG4) ? wr_val
                : regs_reg[sio_cfg_pkg::REG_CFG4];
        dec.r6  = (wr_en && index_reg == sio_cfg_pkg::REG_CFG6) ? wr_val
                : regs_reg[sio_cfg_pkg::REG_CFG6];
        dec.ide = ide_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sio_cfg_pkg::NREGS; i++)
            begin
                regs_reg[i] <= sio_cfg_pkg::reg_reset(sio_cfg_pkg::IDX_W'(i));
            end
            ide_reg      <= sio_cfg_pkg::IDE_NONE;
            unlocked_reg <= 1'b0;
            index_reg    <= '0;
            lock_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ide_reg                          <= cfg_data;
                regs_reg[sio_cfg_pkg::REG_CFG0] <= sio_cfg_pkg::reg0_strap(cfg_data);
            end
            else if (wr_en)
            begin
                regs_reg[index_reg] <= wr_val;
            end
            unlocked_reg <= unlocked_next;
            index_reg    <= index_next;
            lock_reg     <= lock_next;
        end
    end

    // once set, the lock blocks the only write that could clear it
    `SIO_ASSERT_NEXT(a_lock_sticky, clk, rst_n, lock_reg, lock_reg)
    `SIO_ASSERT_NOW(a_index_range, clk, rst_n, 1'b1,
        index_reg <= sio_cfg_pkg::IDX_W'(sio_cfg_pkg::MAX_INDEX))
    `SIO_ASSERT_NOW(a_reg6_masked, clk, rst_n, 1'b1,
        regs_reg[sio_cfg_pkg::REG_CFG6][3:2] == 2'b00)

endmodule

@@ rtl/sio_cfg_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sio_cfg_decode
// serial, parallel, floppy and ide resource decode from register values
// ----------------------------------------------------------------------------
module sio_cfg_decode (
    input  sio_cfg_pkg::dec_regs_t regs_in,
    output sio_cfg_pkg::res_t      res
);

    // one serial port; is_b picks the second port's address and irq pairing
    function automatic logic [14:0] uart_dec(logic s0, logic s1, logic s2,
                                             logic dis, logic is_b);
        logic [9:0] a;
        logic [3:0] q;
        logic       en;
        a  = '0;
        q  = '0;
        en = 1'b1;
        if (s2)
        begin
            a = is_b ? sio_cfg_pkg::COM_3F8 : sio_cfg_pkg::COM_2F8;
            q = is_b ? sio_cfg_pkg::IRQ4 : sio_cfg_pkg::IRQ3;
        end
        else
        begin
            case ({s1, s0})
                2'b00:
                begin
                    a = is_b ? sio_cfg_pkg::COM_3E8 : sio_cfg_pkg::COM_2E8;
                    q = is_b ? sio_cfg_pkg::IRQ4 : sio_cfg_pkg::IRQ3;
                end
                2'b01:
                begin
                    a = is_b ? sio_cfg_pkg::COM_2E8 : sio_cfg_pkg::COM_3E8;
                    q = is_b ? sio_cfg_pkg::IRQ3 : sio_cfg_pkg::IRQ4;
                end
                2'b10:
                begin
                    a = is_b ? sio_cfg_pkg::COM_2F8 : sio_cfg_pkg::COM_3F8;
                    q = is_b ? sio_cfg_pkg::IRQ3 : sio_cfg_pkg::IRQ4;
                end
                default:
                    en = 1'b0;
            endcase
        end
        if (dis)
            en = 1'b0;
        return en ? {a, q, 1'b1} : 15'd0;
    endfunction

    logic [9:0] lpt_a;
    logic [3:0] lpt_q;
    logic       lpt_en;

    always_comb
    begin
        {res.uart_a_addr, res.uart_a_irq, res.uart_a_on} =
            uart_dec(regs_in.r1[0], regs_in.r1[2], regs_in.r3[3], regs_in.r4[5], 1'b0);
        {res.uart_b_addr, res.uart_b_irq, res.uart_b_on} =
            uart_dec(regs_in.r1[1], regs_in.r1[3], regs_in.r3[2], regs_in.r4[4], 1'b1);

        lpt_a  = '0;
        lpt_q  = '0;
        lpt_en = 1'b1;
        case (regs_in.r1[5:4])
            2'b00:
            begin
                lpt_a = sio_cfg_pkg::LPT_3BC;
                lpt_q = sio_cfg_pkg::IRQ7;
            end
            2'b01:
            begin
                lpt_a = sio_cfg_pkg::LPT_278;
                lpt_q = sio_cfg_pkg::IRQ5;
            end
            2'b10:
            begin
                lpt_a = sio_cfg_pkg::LPT_378;
                lpt_q = sio_cfg_pkg::IRQ7;
            end
            default:
                lpt_en = 1'b0;
        endcase
        if (regs_in.r4[7])
            lpt_en = 1'b0;
        res.printer_addr = lpt_en ? lpt_a : '0;
        res.printer_irq  = lpt_en ? lpt_q : '0;
        res.printer_on   = lpt_en;

        if (regs_in.r0[5] || regs_in.r6[3])
            res.floppy_mode = sio_cfg_pkg::MODE_OFF;
        else
            res.floppy_mode = regs_in.r0[4] ? sio_cfg_pkg::MODE_PRIMARY
                                            : sio_cfg_pkg::MODE_SECONDARY;
        if (regs_in.ide == sio_cfg_pkg::IDE_NONE || regs_in.r0[7])
            res.disk_mode = sio_cfg_pkg::MODE_OFF;
        else
            res.disk_mode = regs_in.r0[6] ? sio_cfg_pkg::MODE_PRIMARY
                                          : sio_cfg_pkg::MODE_SECONDARY;
    end

endmodule
